// ===== hdl/qvr_pkg.sv =====
// ============================================================================
// qvr_pkg
// Shared types, widths and constants for the quaternion vector rotation core.
// ============================================================================
package qvr_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int WORK_FRAC    = 30;
    localparam int TABLE_LEN    = 32;
    localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    localparam int VEC_W = 18;
    localparam int ANG_W = 20;
    localparam int A_W   = ANG_W + WORK_FRAC - FRAC_BITS + 2;
    localparam int D_W   = 34;
    localparam int P_W   = 2 * D_W;
    localparam int S_W   = P_W + 2;
    localparam int M_W   = D_W + 2;
    localparam int MV_W  = M_W + VEC_W;
    localparam int ACC_W = MV_W + 2;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [A_W-1:0]   wang_t;
    typedef logic signed [D_W-1:0]   data_t;
    typedef logic signed [P_W-1:0]   prod_t;
    typedef logic signed [S_W-1:0]   sum_t;
    typedef logic signed [M_W-1:0]   mat_t;
    typedef mat_t                    mat9_t [9];

    localparam wang_t PI_Q      = wang_t'(64'sd3373259426);
    localparam wang_t TWO_PI_Q  = wang_t'(64'sd6746518852);
    localparam wang_t HALF_PI_Q = wang_t'(64'sd1686629713);
    localparam data_t GAIN_Q    = data_t'(64'sd652032874);

    localparam logic [31:0] ATAN_TBL [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
        32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // floor shift of a q30 product back to a data word
    function automatic data_t shr_d(prod_t v);
        prod_t t;
        t = v >>> WORK_FRAC;
        return t[D_W-1:0];
    endfunction

    function automatic mat_t shr_m(sum_t v, int s);
        sum_t t;
        t = v >>> s;
        return t[M_W-1:0];
    endfunction

endpackage

// ===== hdl/qvr_in_if.sv =====
// ============================================================================
// qvr_in_if
// Input channel: vector and axis/angle triple with valid/ready handshake.
// ============================================================================
interface qvr_in_if;
    import qvr_pkg::*;

    logic valid;
    logic ready;
    vec_t vec_x;
    vec_t vec_y;
    vec_t vec_z;
    ang_t axis_polar;
    ang_t axis_azimuth;
    ang_t turn_angle;

    modport source (output valid, vec_x, vec_y, vec_z, axis_polar, axis_azimuth,
                    turn_angle, input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, axis_polar, axis_azimuth,
                  turn_angle, output ready);
endinterface

// ===== hdl/qvr_out_if.sv =====
// ============================================================================
// qvr_out_if
// Output channel: rotated vector with valid/ready handshake.
// ============================================================================
interface qvr_out_if;
    import qvr_pkg::*;

    logic valid;
    logic ready;
    vec_t rot_x;
    vec_t rot_y;
    vec_t rot_z;

    modport source (output valid, rot_x, rot_y, rot_z, input ready);
    modport sink (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// ===== hdl/qvr_cordic.sv =====
// ============================================================================
// qvr_cordic
// Range reduction followed by an unrolled rotation-mode CORDIC, one
// iteration per register stage, producing sine and cosine in q30.
// ============================================================================
module qvr_cordic (
    input  logic           clk,
    input  logic           en,
    input  qvr_pkg::wang_t ang,
    output qvr_pkg::data_t sn,
    output qvr_pkg::data_t cs
);
    import qvr_pkg::*;

    wang_t a_wrap;
    wang_t a_red;
    logic  flip;

    wang_t a_reg [NSTEPS];
    data_t x_reg [NSTEPS+1];
    data_t y_reg [NSTEPS+1];
    logic  f_reg [NSTEPS+1];

    always_comb
    begin
        if (ang > PI_Q)
        begin
            a_wrap = ang - TWO_PI_Q;
        end
        else if (ang <= -PI_Q)
        begin
            a_wrap = ang + TWO_PI_Q;
        end
        else
        begin
            a_wrap = ang;
        end
        flip = 1'b1;
        if (a_wrap > HALF_PI_Q)
        begin
            a_red = a_wrap - PI_Q;
        end
        else if (a_wrap < -HALF_PI_Q)
        begin
            a_red = a_wrap + PI_Q;
        end
        else
        begin
            a_red = a_wrap;
            flip  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= a_red;
            x_reg[0] <= GAIN_Q;
            y_reg[0] <= '0;
            f_reg[0] <= flip;
        end
    end

    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_step
        localparam wang_t ATN = wang_t'({1'b0, ATAN_TBL[i]});
        data_t x_sh;
        data_t y_sh;
        data_t x_next;
        data_t y_next;

        assign x_sh = x_reg[i] >>> i;
        assign y_sh = y_reg[i] >>> i;

        always_comb
        begin
            if (a_reg[i] >= 0)
            begin
                x_next = x_reg[i] - y_sh;
                y_next = y_reg[i] + x_sh;
            end
            else
            begin
                x_next = x_reg[i] + y_sh;
                y_next = y_reg[i] - x_sh;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                f_reg[i+1] <= f_reg[i];
            end
        end

        // residual angle is only needed up to the last iteration
        if (i < NSTEPS - 1)
        begin : g_ang
            wang_t a_next;

            assign a_next = (a_reg[i] >= 0) ? a_reg[i] - ATN : a_reg[i] + ATN;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[i+1] <= a_next;
                end
            end
        end
    end

    assign sn = f_reg[NSTEPS] ? -y_reg[NSTEPS] : y_reg[NSTEPS];
    assign cs = f_reg[NSTEPS] ? -x_reg[NSTEPS] : x_reg[NSTEPS];

endmodule

// ===== hdl/qvr_matrix.sv =====
// ============================================================================
// qvr_matrix
// Builds the unit quaternion from the sines and cosines and expands it into
// the 3x3 rotation matrix over four register stages.
// ============================================================================
module qvr_matrix (
    input  logic           clk,
    input  logic           en,
    input  qvr_pkg::data_t sb,
    input  qvr_pkg::data_t cb,
    input  qvr_pkg::data_t st,
    input  qvr_pkg::data_t ct,
    input  qvr_pkg::data_t sp,
    input  qvr_pkg::data_t cp,
    output qvr_pkg::mat9_t m
);
    import qvr_pkg::*;

    data_t sbst_reg, q0a_reg, q3a_reg, cp_reg, sp_reg;
    data_t q0_reg, q1_reg, q2_reg, q3_reg;
    prod_t p00_reg, p11_reg, p22_reg, p33_reg;
    prod_t p12_reg, p03_reg, p13_reg, p02_reg, p23_reg, p01_reg;
    mat9_t m_reg;

    prod_t sbst_p, q3_p, q1_p, q2_p;
    sum_t  s00, s11, s22, s12a, s12b, s13a, s13b, s23a, s23b;

    assign sbst_p = sb * st;
    assign q3_p   = sb * ct;
    assign q1_p   = sbst_reg * cp_reg;
    assign q2_p   = sbst_reg * sp_reg;

    assign s00  = sum_t'(p00_reg) + p11_reg - p22_reg - p33_reg;
    assign s11  = sum_t'(p00_reg) - p11_reg + p22_reg - p33_reg;
    assign s22  = sum_t'(p00_reg) - p11_reg - p22_reg + p33_reg;
    assign s12a = sum_t'(p12_reg) - p03_reg;
    assign s12b = sum_t'(p12_reg) + p03_reg;
    assign s13a = sum_t'(p13_reg) + p02_reg;
    assign s13b = sum_t'(p13_reg) - p02_reg;
    assign s23a = sum_t'(p23_reg) - p01_reg;
    assign s23b = sum_t'(p23_reg) + p01_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quaternion partials
            sbst_reg <= shr_d(sbst_p);
            q3a_reg  <= shr_d(q3_p);
            q0a_reg  <= cb;
            cp_reg   <= cp;
            sp_reg   <= sp;
            // quaternion
            q0_reg   <= q0a_reg;
            q1_reg   <= shr_d(q1_p);
            q2_reg   <= shr_d(q2_p);
            q3_reg   <= q3a_reg;
            // pairwise products
            p00_reg  <= q0_reg * q0_reg;
            p11_reg  <= q1_reg * q1_reg;
            p22_reg  <= q2_reg * q2_reg;
            p33_reg  <= q3_reg * q3_reg;
            p12_reg  <= q1_reg * q2_reg;
            p03_reg  <= q0_reg * q3_reg;
            p13_reg  <= q1_reg * q3_reg;
            p02_reg  <= q0_reg * q2_reg;
            p23_reg  <= q2_reg * q3_reg;
            p01_reg  <= q0_reg * q1_reg;
            // matrix, off-diagonal carries the factor two
            m_reg[0] <= shr_m(s00, WORK_FRAC);
            m_reg[1] <= shr_m(s12a, WORK_FRAC - 1);
            m_reg[2] <= shr_m(s13a, WORK_FRAC - 1);
            m_reg[3] <= shr_m(s12b, WORK_FRAC - 1);
            m_reg[4] <= shr_m(s11, WORK_FRAC);
            m_reg[5] <= shr_m(s23a, WORK_FRAC - 1);
            m_reg[6] <= shr_m(s13b, WORK_FRAC - 1);
            m_reg[7] <= shr_m(s23b, WORK_FRAC - 1);
            m_reg[8] <= shr_m(s22, WORK_FRAC);
        end
    end

    assign m = m_reg;

endmodule

// ===== hdl/quaternion_vector_rotate_core.sv =====
// ============================================================================
// quaternion_vector_rotate_core
// Rotates a Q1.16 vector about a spherical-angle axis by a turn angle.
// ============================================================================
// Fully pipelined: one vector is taken every cycle while the output is not
// held. The pipeline is the range-reduced CORDIC input register and the
// unrolled CORDIC, one iteration per stage, followed by two
// quaternion stages, a product stage, a matrix stage, the matrix-vector
// product stage and the saturating output register. When the output is held
// the whole pipeline holds.
module quaternion_vector_rotate_core (
    input logic      clk,
    input logic      rst_n,
    qvr_in_if.sink   vin,
    qvr_out_if.source vout
);
    import qvr_pkg::*;

    localparam int DEPTH = NSTEPS + 7;
    localparam int VD    = NSTEPS + 5;
    localparam int SH    = WORK_FRAC - FRAC_BITS;

    logic  en;
    logic  vld_reg [DEPTH];
    vec_t  vx_reg [VD];
    vec_t  vy_reg [VD];
    vec_t  vz_reg [VD];

    wang_t polar_w, azim_w, turn_w, half_w;
    data_t sb, cb, st, ct, sp, cp;
    mat9_t m;

    logic signed [MV_W-1:0] mv_reg [9];
    logic signed [ACC_W-1:0] acc [3];
    vec_t rot_reg [3];

    assign en        = !vld_reg[DEPTH-1] || vout.ready;
    assign vin.ready = en;

    assign polar_w = wang_t'(vin.axis_polar) <<< SH;
    assign azim_w  = wang_t'(vin.axis_azimuth) <<< SH;
    assign turn_w  = wang_t'(vin.turn_angle) <<< SH;
    // halve with truncation toward zero
    assign half_w  = (turn_w + wang_t'(turn_w < 0)) >>> 1;

    qvr_cordic u_cordic_t (.clk, .en, .ang(polar_w), .sn(st), .cs(ct));
    qvr_cordic u_cordic_p (.clk, .en, .ang(azim_w),  .sn(sp), .cs(cp));
    qvr_cordic u_cordic_b (.clk, .en, .ang(half_w),  .sn(sb), .cs(cb));

    qvr_matrix u_matrix (
        .clk, .en, .sb, .cb, .st, .ct, .sp, .cp, .m
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= vin.valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= vin.vec_x;
            vy_reg[0] <= vin.vec_y;
            vz_reg[0] <= vin.vec_z;
            for (int i = 1; i < VD; i++)
            begin
                vx_reg[i] <= vx_reg[i-1];
                vy_reg[i] <= vy_reg[i-1];
                vz_reg[i] <= vz_reg[i-1];
            end
            for (int r = 0; r < 3; r++)
            begin
                mv_reg[3*r]   <= m[3*r]   * vx_reg[VD-1];
                mv_reg[3*r+1] <= m[3*r+1] * vy_reg[VD-1];
                mv_reg[3*r+2] <= m[3*r+2] * vz_reg[VD-1];
            end
            for (int r = 0; r < 3; r++)
            begin
                if (acc[r] > ACC_W'(131071))
                begin
                    rot_reg[r] <= vec_t'(131071);
                end
                else if (acc[r] < -ACC_W'(131072))
                begin
                    rot_reg[r] <= vec_t'(-131072);
                end
                else
                begin
                    rot_reg[r] <= acc[r][VEC_W-1:0];
                end
            end
        end
    end

    // round to nearest, ties up, then floor shift
    for (genvar r = 0; r < 3; r++)
    begin : g_acc
        logic signed [ACC_W-1:0] sum;
        assign sum    = ACC_W'(mv_reg[3*r]) + mv_reg[3*r+1] + mv_reg[3*r+2]
                      + (ACC_W'(1) <<< (WORK_FRAC - 1));
        assign acc[r] = sum >>> WORK_FRAC;
    end

    assign vout.valid = vld_reg[DEPTH-1];
    assign vout.rot_x = rot_reg[0];
    assign vout.rot_y = rot_reg[1];
    assign vout.rot_z = rot_reg[2];

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        vin.valid && vin.ready |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_reg[0] == $past(vld_reg[0]) && vout.valid)
        else $error("pipeline moved during a stall");

    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[DEPTH-2] |=> vout.valid)
        else $error("pipeline item lost before output");

endmodule
